### rtl/core/nps_pkg.sv
package nps_pkg;

    localparam int MAX_NODES = 4096;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = 13;
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = 50;
    localparam int ID_W      = 13;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             store;
        logic             load_query;
        logic             issue;
        logic [IDX_W-1:0] rd_addr;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_empty;
    } t_dp_stat;

endpackage

### rtl/core/nps_ctrl.sv
module nps_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_action,
    input  logic                      i_cfg_we,
    input  logic [nps_pkg::CNT_W-1:0] i_cfg_wdata,
    input  nps_pkg::t_dp_stat         i_stat,
    output nps_pkg::t_dp_cmd          o_cmd,
    output logic                      o_busy,
    output logic                      o_done
);

    nps_pkg::t_state                r_state, n_state;
    logic [nps_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [nps_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [nps_pkg::CNT_W-1:0]      r_node_count;
    logic [nps_pkg::CNT_W-1:0]      clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nps_pkg::ST_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    // counts above capacity search the whole store
    assign clamped = (r_node_count > nps_pkg::CNT_W'(nps_pkg::MAX_NODES))
                     ? nps_pkg::CNT_W'(nps_pkg::MAX_NODES) : r_node_count;

    always_comb begin
        n_state            = r_state;
        n_idx              = r_idx;
        n_cnt              = r_cnt;
        o_cmd.store        = 1'b0;
        o_cmd.load_query   = 1'b0;
        o_cmd.issue        = 1'b0;
        o_cmd.rd_addr      = r_idx;
        unique case (r_state)
            nps_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_action == nps_pkg::ACT_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_idx            = '0;
                        n_cnt            = clamped;
                        n_state          = (clamped == '0) ? nps_pkg::ST_DRAIN
                                                           : nps_pkg::ST_SCAN;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            nps_pkg::ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if ({1'b0, r_idx} == r_cnt - nps_pkg::CNT_W'(1)) begin
                    n_state = nps_pkg::ST_DRAIN;
                end else begin
                    n_idx = r_idx + nps_pkg::IDX_W'(1);
                end
            end
            nps_pkg::ST_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = nps_pkg::ST_DONE;
                end
            end
            nps_pkg::ST_DONE: begin
                n_state = nps_pkg::ST_IDLE;
            end
            default: begin
                n_state = nps_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != nps_pkg::ST_IDLE);
    assign o_done = (r_state == nps_pkg::ST_DONE);

endmodule

### rtl/core/nps_dp.sv
module nps_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nps_pkg::t_dp_cmd                   i_cmd,
    input  logic        [nps_pkg::IDX_W-1:0]   i_slot,
    input  logic signed [nps_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [nps_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [nps_pkg::COORD_W-1:0] i_coord_z,
    output nps_pkg::t_dp_stat                  o_stat,
    output logic        [nps_pkg::ID_W-1:0]    o_nearest_id,
    output logic        [nps_pkg::DIST_W-1:0]  o_best_distance_sq
);

    localparam int CW = nps_pkg::COORD_W;
    localparam int IW = nps_pkg::IDX_W;

    logic [3*CW-1:0] mem [nps_pkg::MAX_NODES];

    logic signed [CW-1:0] r_qx, r_qy, r_qz;

    // pipeline: read, |diff|, square, partial sum, total, compare
    logic                         r_v_rd, r_v_df, r_v_sq, r_v_sa, r_v_tot;
    logic [IW-1:0]                r_t_rd, r_t_df, r_t_sq, r_t_sa, r_t_tot;
    logic [3*CW-1:0]              r_rd_data;
    logic [CW-1:0]                r_ax, r_ay, r_az;
    logic [nps_pkg::SQ_W-1:0]     r_sx, r_sy, r_sz, r_sz_d;
    logic [nps_pkg::DIST_W-1:0]   r_sxy, r_tot;

    logic [nps_pkg::DIST_W-1:0]   r_best;
    logic [nps_pkg::ID_W-1:0]     r_best_id;
    logic                         r_first;

    logic signed [nps_pkg::DIFF_W-1:0] n_dx, n_dy, n_dz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[i_slot] <= {i_coord_x, i_coord_y, i_coord_z};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
            r_qz <= i_coord_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rd  <= 1'b0;
            r_v_df  <= 1'b0;
            r_v_sq  <= 1'b0;
            r_v_sa  <= 1'b0;
            r_v_tot <= 1'b0;
        end else begin
            r_v_rd  <= i_cmd.issue;
            r_v_df  <= r_v_rd;
            r_v_sq  <= r_v_df;
            r_v_sa  <= r_v_sq;
            r_v_tot <= r_v_sa;
        end
    end

    always_comb begin
        n_dx = $signed({r_rd_data[3*CW-1], r_rd_data[3*CW-1:2*CW]})
             - $signed({r_qx[CW-1], r_qx});
        n_dy = $signed({r_rd_data[2*CW-1], r_rd_data[2*CW-1:CW]})
             - $signed({r_qy[CW-1], r_qy});
        n_dz = $signed({r_rd_data[CW-1], r_rd_data[CW-1:0]})
             - $signed({r_qz[CW-1], r_qz});
    end

    always_ff @(posedge i_clk) begin
        r_t_rd  <= i_cmd.rd_addr;
        r_t_df  <= r_t_rd;
        r_t_sq  <= r_t_df;
        r_t_sa  <= r_t_sq;
        r_t_tot <= r_t_sa;
        // magnitude of a 25-bit difference always fits 24 bits
        r_ax    <= n_dx[nps_pkg::DIFF_W-1] ? CW'(-n_dx) : CW'(n_dx);
        r_ay    <= n_dy[nps_pkg::DIFF_W-1] ? CW'(-n_dy) : CW'(n_dy);
        r_az    <= n_dz[nps_pkg::DIFF_W-1] ? CW'(-n_dz) : CW'(n_dz);
        r_sx    <= r_ax * r_ax;
        r_sy    <= r_ay * r_ay;
        r_sz    <= r_az * r_az;
        r_sxy   <= nps_pkg::DIST_W'(r_sx) + nps_pkg::DIST_W'(r_sy);
        r_sz_d  <= r_sz;
        r_tot   <= r_sxy + nps_pkg::DIST_W'(r_sz_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best    <= '0;
            r_best_id <= '0;
            r_first   <= 1'b1;
        end else if (i_cmd.load_query) begin
            r_best    <= '0;
            r_best_id <= '0;
            r_first   <= 1'b1;
        end else if (r_v_tot && (r_first || r_tot < r_best)) begin
            // strict less-than keeps the lowest index on ties
            r_best    <= r_tot;
            r_best_id <= nps_pkg::ID_W'(r_t_tot) + nps_pkg::ID_W'(1);
            r_first   <= 1'b0;
        end
    end

    assign o_stat.pipe_empty  = !(r_v_rd || r_v_df || r_v_sq || r_v_sa || r_v_tot);
    assign o_nearest_id       = r_best_id;
    assign o_best_distance_sq = r_best;

endmodule

### rtl/core/nearest_point_search_core.sv
// Brute-force 3D nearest-node search. A store (i_action 0) writes one node into
// i_slot in a single cycle and returns no result; o_busy stays low. A query
// (i_action 1) streams nodes 0..node_count-1 out of the node RAM one per
// cycle through a six-stage distance pipeline; o_busy stays high through the
// scan, the drain and the result, and the controller's scan state sets that
// one-node-per-cycle pace. The result is shown for exactly one cycle with
// o_done and cannot be held off, so the receiver must take it then. Reading
// a slot never written since reset gives an undefined distance.
module nearest_point_search_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_cfg_we,
    input  logic        [nps_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic                               i_action,
    input  logic        [nps_pkg::IDX_W-1:0]   i_slot,
    input  logic signed [nps_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [nps_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [nps_pkg::COORD_W-1:0] i_coord_z,
    output logic                               o_done,
    output logic        [nps_pkg::ID_W-1:0]    o_nearest_id,
    output logic        [nps_pkg::DIST_W-1:0]  o_best_distance_sq
);

    nps_pkg::t_dp_cmd  cmd;
    nps_pkg::t_dp_stat stat;

    nps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_action    (i_action),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_done      (o_done)
    );

    nps_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_slot             (i_slot),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_coord_z          (i_coord_z),
        .o_stat             (stat),
        .o_nearest_id       (o_nearest_id),
        .o_best_distance_sq (o_best_distance_sq)
    );

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result strobe outside a query");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_action == nps_pkg::ACT_QUERY) |=> o_busy)
        else $error("query transaction did not start a search");

    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_action == nps_pkg::ACT_STORE) |=> !o_busy)
        else $error("store transaction left the block busy");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_nearest_id <= nps_pkg::ID_W'(nps_pkg::MAX_NODES)))
        else $error("nearest id beyond capacity");

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nps_pkg::*;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam int                        FILL_SLOTS = 32;

    typedef struct {
        logic                      action;
        logic [IDX_W-1:0]          slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_node_op;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dist_sq;
    } t_nearest;

    logic                      i_clk              = 1'b0;
    logic                      i_rst_n            = 1'b0;
    logic                      i_start            = 1'b0;
    logic                      i_cfg_we           = 1'b0;
    logic [CNT_W-1:0]          i_cfg_wdata        = '0;
    logic                      i_action           = ACT_STORE;
    logic [IDX_W-1:0]          i_slot             = '0;
    logic signed [COORD_W-1:0] i_coord_x          = '0;
    logic signed [COORD_W-1:0] i_coord_y          = '0;
    logic signed [COORD_W-1:0] i_coord_z          = '0;
    logic                      o_busy;
    logic                      o_done;
    logic [ID_W-1:0]           o_nearest_id;
    logic [DIST_W-1:0]         o_best_distance_sq;

    nearest_point_search_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_action           (i_action),
        .i_slot             (i_slot),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_coord_z          (i_coord_z),
        .o_done             (o_done),
        .o_nearest_id       (o_nearest_id),
        .o_best_distance_sq (o_best_distance_sq)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's node store and count register
    logic signed [COORD_W-1:0] node_x [MAX_NODES];
    logic signed [COORD_W-1:0] node_y [MAX_NODES];
    logic signed [COORD_W-1:0] node_z [MAX_NODES];
    int unsigned               node_count_cfg = 0;

    t_node_op pending_ops [$];
    t_nearest nearest_expected [$];
    t_node_op held_op;
    bit       op_held     = 1'b0;
    int       burst_left  = 0;
    int       gap_left    = 0;
    int       mismatches  = 0;

    initial begin
        for (int i = 0; i < MAX_NODES; i++) begin
            node_x[i] = '0;
            node_y[i] = '0;
            node_z[i] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic longint axis_term(input logic signed [COORD_W-1:0] a,
                                         input logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    // applies one accepted transaction to the shadow store; a query queues its answer
    task automatic apply_node_op(input t_node_op op);
        int unsigned searched;
        int unsigned best_id;
        longint      best;
        longint      d;
        t_nearest    r;
        if (op.action == ACT_STORE) begin
            node_x[op.slot] = op.x;
            node_y[op.slot] = op.y;
            node_z[op.slot] = op.z;
        end else begin
            searched = (node_count_cfg > MAX_NODES) ? MAX_NODES : node_count_cfg;
            best_id  = 0;
            best     = 0;
            for (int i = 0; i < searched; i++) begin
                d = axis_term(node_x[i], op.x) + axis_term(node_y[i], op.y)
                  + axis_term(node_z[i], op.z);
                if (i == 0 || d < best) begin
                    best    = d;
                    best_id = i + 1;
                end
            end
            r.id      = best_id[ID_W-1:0];
            r.dist_sq = best[DIST_W-1:0];
            nearest_expected.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            op_held = 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                apply_node_op(held_op);
                op_held = 1'b0;
            end
            if (!op_held) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() > 0) begin
                    held_op = pending_ops.pop_front();
                    op_held = 1'b1;
                    i_action  <= held_op.action;
                    i_slot    <= held_op.slot;
                    i_coord_x <= held_op.x;
                    i_coord_y <= held_op.y;
                    i_coord_z <= held_op.z;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(0, 6);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_start <= op_held;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (nearest_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result id=%0d dist=%0d",
                                          o_nearest_id, o_best_distance_sq));
            end else begin
                if (o_nearest_id !== nearest_expected[0].id)
                    report_mismatch($sformatf("nearest_id got %0d exp %0d",
                                              o_nearest_id, nearest_expected[0].id));
                if (o_best_distance_sq !== nearest_expected[0].dist_sq)
                    report_mismatch($sformatf("best_distance_sq got %0d exp %0d",
                                              o_best_distance_sq,
                                              nearest_expected[0].dist_sq));
                void'(nearest_expected.pop_front());
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int v;
        case ($urandom_range(0, 7))
            0, 1, 2: return COORD_W'($urandom);
            3, 4, 5: begin
                // tight cluster so that equal distances come up often
                v = int'($urandom_range(0, 32)) - 16;
                return v[COORD_W-1:0];
            end
            6:       return COORD_MAX;
            default: return COORD_MIN;
        endcase
    endfunction

    function automatic void push_store(input int slot, input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic signed [COORD_W-1:0] z);
        t_node_op op;
        op.action = ACT_STORE;
        op.slot   = slot[IDX_W-1:0];
        op.x      = x;
        op.y      = y;
        op.z      = z;
        pending_ops.push_back(op);
    endfunction

    function automatic void push_query(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic signed [COORD_W-1:0] z);
        t_node_op op;
        op.action = ACT_QUERY;
        op.slot   = IDX_W'($urandom);
        op.x      = x;
        op.y      = y;
        op.z      = z;
        pending_ops.push_back(op);
    endfunction

    // waits for all transactions and results, then lets a query's latency pass
    task automatic wait_idle();
        int guard;
        int drain;
        guard = 0;
        while ((pending_ops.size() != 0 || op_held || nearest_expected.size() != 0)
               && guard < 2000000) begin
            @(negedge i_clk);
            guard++;
        end
        drain = ((node_count_cfg > MAX_NODES) ? MAX_NODES : node_count_cfg) + 16;
        repeat (drain) @(posedge i_clk);
    endtask

    task automatic set_node_count(input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        node_count_cfg = value & ((1 << CNT_W) - 1);
    endtask

    initial begin
        int unsigned count;
        int          hi_slot;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty search, then load four nodes: min corner, max corner twice, origin
        set_node_count(0);
        push_query('0, '0, '0);
        push_query(COORD_MAX, COORD_MIN, COORD_MAX);
        push_store(0, COORD_MIN, COORD_MIN, COORD_MIN);
        push_store(1, COORD_MAX, COORD_MAX, COORD_MAX);
        push_store(2, COORD_MAX, COORD_MAX, COORD_MAX);
        push_store(3, '0, '0, '0);
        wait_idle();

        set_node_count(4);
        push_query(COORD_MAX, COORD_MAX, COORD_MAX);   // tie between two nodes
        push_query(COORD_MIN, COORD_MIN, COORD_MIN);
        push_query('0, '0, '0);
        push_query(COORD_MAX, COORD_MIN, '0);
        wait_idle();

        // largest possible distance
        set_node_count(1);
        push_query(COORD_MAX, COORD_MAX, COORD_MAX);
        push_query(COORD_MIN, COORD_MIN, COORD_MIN);
        wait_idle();

        // fill the low slots so every count used below is legal
        for (int s = 0; s < FILL_SLOTS; s++)
            push_store(s, rand_coord(), rand_coord(), rand_coord());
        wait_idle();

        // random phases: fresh count, then mixed stores and queries
        for (int p = 0; p < 5; p++) begin
            case ($urandom_range(0, 5))
                0:       count = 0;
                1, 2, 3: count = $urandom_range(1, 16);
                default: count = $urandom_range(17, FILL_SLOTS);
            endcase
            set_node_count(count);
            hi_slot = (count > 0) ? count - 1 : 15;
            for (int k = 0; k < 20; k++) begin
                if ($urandom_range(0, 9) < 6)
                    push_query(rand_coord(), rand_coord(), rand_coord());
                else if ($urandom_range(0, 9) < 7)
                    push_store($urandom_range(0, hi_slot), rand_coord(), rand_coord(),
                               rand_coord());
                else
                    push_store($urandom_range(0, MAX_NODES - 1), rand_coord(), rand_coord(),
                               rand_coord());
            end
            wait_idle();
        end

        if (nearest_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", nearest_expected.size()));
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/nps_pkg.sv
rtl/core/nps_ctrl.sv
rtl/core/nps_dp.sv
rtl/core/nearest_point_search_core.sv
tb/testbench.sv
